@@ hdl/c3v_pkg.sv @@
`default_nettype none
package c3v_pkg;

  localparam int COEF_BITS     = 16;
  localparam int KERNEL_BITS   = 3 * COEF_BITS;
  localparam int ROW_BITS      = 16;
  localparam int FW_BITS       = 7;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;
  localparam int FIFO_DEPTH    = 8;

  localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RESET  = FW_BITS'(4);
  localparam logic [ROW_BITS-1:0] FRAME_HEIGHT_RESET = ROW_BITS'(4);

  typedef enum logic [2:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MID    = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4
  } reg_idx_e;

endpackage
`default_nettype wire

@@ hdl/conv2d_3x3_valid.sv @@
`default_nettype none
// Streaming 3x3 convolution over a raster-order sample stream, stride 1, valid windows only.
// Input channel: in_valid_i/in_ready_o with pixel_value_i and frame_start_i; one sample per
// beat. Output channel: out_valid_o/out_ready_i with conv_value_o, out_row_o, out_col_o and
// last_of_frame_o; one beat for every sample that completes a full window.
// Throughput is one sample per cycle while in_ready_o is high. The edge that accepts a sample
// also starts the line-store read; the window shift, the nine cell multipliers, two adder
// stages and the queue write follow in that order before the result leaves the output.
// The pipeline itself never stalls; results collect in an eight-entry output queue, and
// in_ready_o drops only when eight results are in flight or queued, so a stalled receiver
// holds back the input as soon as eight results are outstanding.
// Kernel rows and frame size are 64-bit APB registers at byte addresses 0, 8, 16, 24, 32;
// the user must write them only while the block is idle; the block does not enforce this.
// Reset clears the window, counters, queue and registers (frame size 4x4, kernel zero).
// The line stores need no clearing pass; entries read before they are written feed no result.
module conv2d_3x3_valid
  import c3v_pkg::*;
#(
  parameter int MAX_WIDTH   = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] pixel_value_i,
  input  wire logic                          frame_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS+COEF_BITS+3:0] conv_value_o,
  output logic [ROW_BITS-1:0]                out_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_col_o,
  output logic                               last_of_frame_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]      paddr,
  input  wire logic [CFG_DATA_BITS-1:0]      pwdata,
  output logic [CFG_DATA_BITS-1:0]           prdata,
  output logic                               pready
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WB        = (FW_BITS > $clog2(MAX_WIDTH+1)) ? FW_BITS : $clog2(MAX_WIDTH+1);
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int OUT_BITS  = PROD_BITS + 4;
  localparam int PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS  = $clog2(FIFO_DEPTH+1);
  localparam int LAT       = 5;

  typedef struct packed {
    logic                produce;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } meta_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } result_t;

  // Configuration registers.
  logic [KERNEL_BITS-1:0] kernel_q [3];
  logic [FW_BITS-1:0]     frame_width_q;
  logic [ROW_BITS-1:0]    frame_height_q;
  logic                   cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0]    <= '0;
      kernel_q[1]    <= '0;
      kernel_q[2]    <= '0;
      frame_width_q  <= FRAME_WIDTH_RESET;
      frame_height_q <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        REG_KERNEL_TOP:    kernel_q[0]    <= pwdata[KERNEL_BITS-1:0];
        REG_KERNEL_MID:    kernel_q[1]    <= pwdata[KERNEL_BITS-1:0];
        REG_KERNEL_BOTTOM: kernel_q[2]    <= pwdata[KERNEL_BITS-1:0];
        REG_FRAME_WIDTH:   frame_width_q  <= pwdata[FW_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height_q <= pwdata[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_KERNEL_TOP:    prdata = CFG_DATA_BITS'(kernel_q[0]);
      REG_KERNEL_MID:    prdata = CFG_DATA_BITS'(kernel_q[1]);
      REG_KERNEL_BOTTOM: prdata = CFG_DATA_BITS'(kernel_q[2]);
      REG_FRAME_WIDTH:   prdata = CFG_DATA_BITS'(frame_width_q);
      REG_FRAME_HEIGHT:  prdata = CFG_DATA_BITS'(frame_height_q);
      default:           prdata = '0;
    endcase
  end

  // Position counters and the accept stage.
  logic [COL_BITS-1:0] col_q, col_d, cur_col;
  logic [ROW_BITS-1:0] row_q, row_d, cur_row;
  logic [WB-1:0]       width_eff, fw_ext, col_ext;
  logic [ROW_BITS-1:0] height_eff;
  logic                col_wrap, row_wrap, produce, last_win;
  logic                take;
  logic [CNT_BITS-1:0] credit_q;

  assign in_ready_o = credit_q < CNT_BITS'(FIFO_DEPTH);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    fw_ext  = WB'(frame_width_q);
    col_ext = WB'(cur_col);
    if (fw_ext < WB'(3)) begin
      width_eff = WB'(3);
    end else if (fw_ext > WB'(MAX_WIDTH)) begin
      width_eff = WB'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
    height_eff = (frame_height_q < ROW_BITS'(3)) ? ROW_BITS'(3) : frame_height_q;
    col_wrap   = (col_ext + WB'(1)) >= width_eff;
    row_wrap   = ({1'b0, cur_row} + (ROW_BITS+1)'(1)) >= {1'b0, height_eff};
    produce    = (cur_row >= ROW_BITS'(2)) && (col_ext >= WB'(2));
    last_win   = (cur_row == height_eff - ROW_BITS'(1)) && (col_ext == width_eff - WB'(1));
    if (col_wrap) begin
      col_d = '0;
      row_d = row_wrap ? '0 : cur_row + ROW_BITS'(1);
    end else begin
      col_d = cur_col + COL_BITS'(1);
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: read on accept, written back in the cycle after.
  logic                          s1_valid_q, s1_hit_q;
  logic signed [SAMPLE_BITS-1:0] s1_pix_q, byp_top_q, byp_mid_q;
  logic [COL_BITS-1:0]           s1_addr_q;
  logic [SAMPLE_BITS-1:0]        older_rd, newer_rd;
  logic signed [SAMPLE_BITS-1:0] win_top, win_mid;

  // A frame start can repeat column zero on back-to-back beats; the read then
  // races the pending write, so the written values are forwarded.
  assign win_top = s1_hit_q ? byp_top_q : $signed(older_rd);
  assign win_mid = s1_hit_q ? byp_mid_q : $signed(newer_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_pix_q  <= pixel_value_i;
      s1_addr_q <= cur_col;
      s1_hit_q  <= s1_valid_q && (s1_addr_q == cur_col);
      byp_top_q <= win_mid;
      byp_mid_q <= s1_pix_q;
    end
  end

  c3v_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (win_mid),
    .re_i    (take),
    .raddr_i (cur_col),
    .rdata_o (older_rd)
  );

  c3v_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (take),
    .raddr_i (cur_col),
    .rdata_o (newer_rd)
  );

  // Window: three chains of three cells, newest column on the right.
  logic signed [SAMPLE_BITS-1:0] new_tap [3];
  logic signed [SAMPLE_BITS-1:0] tap [3][3];
  logic signed [PROD_BITS-1:0]   prod [9];
  logic signed [OUT_BITS-1:0]    total;

  assign new_tap[0] = win_top;
  assign new_tap[1] = win_mid;
  assign new_tap[2] = s1_pix_q;

  for (genvar kr = 0; kr < 3; kr++) begin : g_row
    for (genvar kc = 0; kc < 3; kc++) begin : g_col
      c3v_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (s1_valid_q),
        .tap_i   ((kc == 2) ? new_tap[kr] : tap[kr][(kc == 2) ? kc : kc + 1]),
        .coef_i  ($signed(kernel_q[kr][COEF_BITS*kc +: COEF_BITS])),
        .tap_o   (tap[kr][kc]),
        .prod_o  (prod[3*kr+kc])
      );
    end
  end

  c3v_adder_tree #(.PROD_BITS(PROD_BITS)) u_tree (
    .clk_i  (clk_i),
    .prod_i (prod),
    .sum_o  (total)
  );

  // Result tags travel beside the data path.
  meta_t meta_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        meta_q[i] <= '0;
      end
    end else begin
      meta_q[0].produce <= take && produce;
      meta_q[0].row     <= cur_row - ROW_BITS'(2);
      meta_q[0].col     <= cur_col - COL_BITS'(2);
      meta_q[0].last    <= last_win;
      for (int i = 1; i < LAT; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // Output queue with credit count over results in flight or queued.
  result_t             fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] fifo_cnt_q;
  logic                push, pop;
  result_t             head;

  assign push = meta_q[LAT-1].produce;
  assign pop  = out_valid_o && out_ready_i;
  assign head = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{value: total, row: meta_q[LAT-1].row,
                            col: meta_q[LAT-1].col, last: meta_q[LAT-1].last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      credit_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_BITS'(push) - CNT_BITS'(pop);
      credit_q   <= credit_q + CNT_BITS'(take && produce) - CNT_BITS'(pop);
    end
  end

  assign out_valid_o     = fifo_cnt_q != '0;
  assign conv_value_o    = $signed(head.value);
  assign out_row_o       = head.row;
  assign out_col_o       = head.col;
  assign last_of_frame_o = head.last;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CNT_BITS'(FIFO_DEPTH))
    else $error("credit count exceeds queue depth");

  a_queue_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= credit_q)
    else $error("queued results exceed issued credits");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < CNT_BITS'(FIFO_DEPTH)) || pop)
    else $error("result pushed into a full queue");

  a_hit_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && s1_valid_q && (s1_addr_q == cur_col) |=> s1_hit_q)
    else $error("line store forward missed");

endmodule
`default_nettype wire

@@ hdl/c3v_ram.sv @@
`default_nettype none
module c3v_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/c3v_tap_cell.sv @@
`default_nettype none
module c3v_tap_cell
  import c3v_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                shift_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       tap_i,
  input  wire logic signed [COEF_BITS-1:0]         coef_i,
  output logic signed      [SAMPLE_BITS-1:0]       tap_o,
  output logic signed      [SAMPLE_BITS+COEF_BITS-1:0] prod_o
);

  logic signed [SAMPLE_BITS-1:0] tap_q;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= tap_i;
    end
  end

  // The product is registered, so it follows the tap in the cycle after.
  always_ff @(posedge clk_i) begin
    prod_q <= tap_q * coef_i;
  end

  assign tap_o  = tap_q;
  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ hdl/c3v_adder_tree.sv @@
`default_nettype none
module c3v_adder_tree #(
  parameter int PROD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic signed [PROD_BITS-1:0] prod_i [9],
  output logic signed      [PROD_BITS+3:0] sum_o
);

  logic signed [PROD_BITS+1:0] row_d [3];
  logic signed [PROD_BITS+1:0] row_q [3];
  logic signed [PROD_BITS+3:0] sum_d;
  logic signed [PROD_BITS+3:0] sum_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_d[r] = (PROD_BITS+2)'(prod_i[3*r]) + (PROD_BITS+2)'(prod_i[3*r+1])
               + (PROD_BITS+2)'(prod_i[3*r+2]);
    end
    sum_d = (PROD_BITS+4)'(row_q[0]) + (PROD_BITS+4)'(row_q[1])
          + (PROD_BITS+4)'(row_q[2]);
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import c3v_pkg::*;

  localparam int MAX_W         = 64;
  localparam int SAMPLE_W      = 16;
  localparam int OUT_W         = SAMPLE_W + COEF_BITS + 4;
  localparam int COL_W         = $clog2(MAX_W);
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 950;
  localparam int REPORT_MAX    = 10;
  localparam int SPARE_REG_FIRST = 5;
  localparam int SPARE_REG_LAST  = 7;

  typedef struct packed {
    logic signed [OUT_W-1:0] sum;
    logic [ROW_BITS-1:0]     row;
    logic [COL_W-1:0]        col;
    logic                    last;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] pixel_value = '0;
  logic                       frame_start = 1'b0;
  logic                       out_ready = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   paddr = '0;
  logic [CFG_DATA_BITS-1:0]   pwdata = '0;

  logic                       in_ready;
  logic                       out_valid;
  logic signed [OUT_W-1:0]    conv_value;
  logic [ROW_BITS-1:0]        out_row;
  logic [COL_W-1:0]           out_col;
  logic                       last_of_frame;
  logic [CFG_DATA_BITS-1:0]   prdata;
  logic                       pready;

  conv2d_3x3_valid u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pixel_value_i   (pixel_value),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .conv_value_o    (conv_value),
    .out_row_o       (out_row),
    .out_col_o       (out_col),
    .last_of_frame_o (last_of_frame),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block: line stores, window, position and registers.
  logic signed [SAMPLE_W-1:0] line_older [MAX_W];
  logic signed [SAMPLE_W-1:0] line_newer [MAX_W];
  logic signed [SAMPLE_W-1:0] window_cells [3][3];
  int unsigned                row_pos;
  int unsigned                col_pos;
  logic [KERNEL_BITS-1:0]     kernel_rows [3];
  logic [FW_BITS-1:0]         width_reg;
  logic [ROW_BITS-1:0]        height_reg;
  bit                         restart_due;

  window_result_t expected_sums [$];
  int unsigned    pixels_sent;
  int             mismatch_cnt;
  int             cycle_cnt;
  int             hold_left;
  bit             steady;

  function automatic int unsigned eff_width(logic [FW_BITS-1:0] w);
    if (w < 3) return 3;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  task automatic predict_window(logic signed [SAMPLE_W-1:0] pix, logic fs);
    int unsigned w, h, c, r;
    logic signed [SAMPLE_W-1:0] top, mid;
    longint acc;
    window_result_t res;
    w = eff_width(width_reg);
    h = (height_reg < 3) ? 3 : height_reg;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
    r = row_pos;
    top = line_older[c];
    mid = line_newer[c];
    line_older[c] = mid;
    line_newer[c] = pix;
    for (int kr = 0; kr < 3; kr++) begin
      window_cells[kr][0] = window_cells[kr][1];
      window_cells[kr][1] = window_cells[kr][2];
    end
    window_cells[0][2] = top;
    window_cells[1][2] = mid;
    window_cells[2][2] = pix;
    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (int kr = 0; kr < 3; kr++) begin
        for (int kc = 0; kc < 3; kc++) begin
          acc += longint'(window_cells[kr][kc]) *
                 longint'($signed(kernel_rows[kr][COEF_BITS*kc +: COEF_BITS]));
        end
      end
      res.sum  = acc[OUT_W-1:0];
      res.row  = ROW_BITS'(r - 2);
      res.col  = COL_W'(c - 2);
      res.last = (r == h - 1) && (c == w - 1);
      expected_sums.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 32'hffff);
    end else begin
      col_pos = (c + 1) & (MAX_W - 1);
    end
  endtask

  task automatic write_reg(int idx, logic [CFG_DATA_BITS-1:0] data);
    int unsigned old_w;
    old_w = eff_width(width_reg);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx * 8);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_KERNEL_TOP:    kernel_rows[0] = data[KERNEL_BITS-1:0];
      REG_KERNEL_MID:    kernel_rows[1] = data[KERNEL_BITS-1:0];
      REG_KERNEL_BOTTOM: kernel_rows[2] = data[KERNEL_BITS-1:0];
      REG_FRAME_WIDTH:   width_reg = data[FW_BITS-1:0];
      REG_FRAME_HEIGHT:  height_reg = data[ROW_BITS-1:0];
      default: ;
    endcase
    // Columns beyond the old width hold stale or unwritten data, so the next
    // frame has to begin at row zero before any window reaches them.
    if (eff_width(width_reg) > old_w) restart_due = 1'b1;
    @(posedge clk);
  endtask

  function automatic bit sender_rests();
    if (steady) return 1'b0;
    return $urandom_range(0, 99) < 9;
  endfunction

  task automatic send_pixel(logic signed [SAMPLE_W-1:0] pix, logic fs);
    if (restart_due) begin
      fs = 1'b1;
      restart_due = 1'b0;
    end
    while (sender_rests()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_window(pix, fs);
    pixels_sent++;
  endtask

  // Lets every pending result drain, then gives the pipeline time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_kernel();
    logic [CFG_DATA_BITS-1:0] word;
    word = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: word[KERNEL_BITS-1:0] = {3{16'h8000}};
      1: word[KERNEL_BITS-1:0] = {3{16'h7fff}};
      2: word[KERNEL_BITS-1:0] = '0;
      default: ;
    endcase
    return word;
  endfunction

  // Half the time, garbage above the register's width rides along on the bus.
  function automatic logic [CFG_DATA_BITS-1:0] with_noise(int unsigned value, int bits);
    logic [CFG_DATA_BITS-1:0] word;
    word = '0;
    if ($urandom_range(0, 1)) word = {$urandom, $urandom};
    for (int b = 0; b < bits; b++) word[b] = value[b];
    return word;
  endfunction

  task automatic test_reset_values();
    for (int i = 0; i < 12; i++) send_pixel(pick_sample(), i == 0);
  endtask

  task automatic test_extreme_values();
    settle();
    write_reg(REG_KERNEL_TOP, {16'($urandom), {3{16'h8000}}});
    write_reg(REG_KERNEL_MID, {16'($urandom), {3{16'h8000}}});
    write_reg(REG_KERNEL_BOTTOM, {16'($urandom), {3{16'h8000}}});
    write_reg(REG_FRAME_WIDTH, with_noise(0, FW_BITS));
    write_reg(REG_FRAME_HEIGHT, with_noise(1, ROW_BITS));
    for (int i = 0; i < 9; i++) send_pixel(16'sh8000, i == 0);
    settle();
    write_reg(REG_KERNEL_TOP, {16'($urandom), {3{16'h7fff}}});
    write_reg(REG_KERNEL_MID, {16'($urandom), {3{16'h7fff}}});
    write_reg(REG_KERNEL_BOTTOM, {16'($urandom), {3{16'h7fff}}});
    // No frame start here: the previous frame wrapped the position to zero.
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 16'sh8000 : 16'sh7fff, 1'b0);
  endtask

  task automatic test_frame_extremes();
    settle();
    write_reg(REG_KERNEL_TOP, pick_kernel());
    write_reg(REG_KERNEL_MID, pick_kernel());
    write_reg(REG_KERNEL_BOTTOM, pick_kernel());
    write_reg(REG_FRAME_WIDTH, with_noise(127, FW_BITS));
    write_reg(REG_FRAME_HEIGHT, with_noise(0, ROW_BITS));
    for (int i = 0; i < 3 * MAX_W; i++) send_pixel(pick_sample(), i == 0);
    settle();
    write_reg(REG_FRAME_WIDTH, with_noise(2, FW_BITS));
    write_reg(REG_FRAME_HEIGHT, with_noise(65535, ROW_BITS));
    for (int i = 0; i < 30; i++) send_pixel(pick_sample(), i == 0);
  endtask

  task automatic test_midframe_config();
    settle();
    write_reg(REG_KERNEL_TOP, pick_kernel());
    write_reg(REG_KERNEL_MID, pick_kernel());
    write_reg(REG_KERNEL_BOTTOM, pick_kernel());
    write_reg(REG_FRAME_WIDTH, with_noise(6, FW_BITS));
    write_reg(REG_FRAME_HEIGHT, with_noise(8, ROW_BITS));
    for (int i = 0; i < 27; i++) send_pixel(pick_sample(), i == 0);
    settle();
    // The row counter already sits past the new height and has to wrap.
    write_reg(REG_FRAME_HEIGHT, with_noise(3, ROW_BITS));
    write_reg(REG_KERNEL_MID, pick_kernel());
    for (int idx = SPARE_REG_FIRST; idx <= SPARE_REG_LAST; idx++)
      write_reg(idx, {$urandom, $urandom});
    for (int i = 0; i < 18; i++) send_pixel(pick_sample(), 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, with_noise(4, FW_BITS));
    write_reg(REG_FRAME_HEIGHT, with_noise(5, ROW_BITS));
    for (int i = 0; i < 30; i++) send_pixel(pick_sample(), 1'b0);
  endtask

  task automatic test_random_stream();
    int unsigned start, done, w, h, wv, hv, frame_items, n_frames, phase;
    int pause_at, noise;
    bit leading, fs;
    start = pixels_sent;
    phase = 0;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      settle();
      done = pixels_sent - start;
      steady = (done >= 400) && (done < 700);
      write_reg(REG_KERNEL_TOP, pick_kernel());
      write_reg(REG_KERNEL_MID, pick_kernel());
      write_reg(REG_KERNEL_BOTTOM, pick_kernel());
      case ($urandom_range(0, 19))
        0: wv = $urandom_range(0, 2);
        1: wv = MAX_W;
        2: wv = $urandom_range(MAX_W + 1, 127);
        3, 4: wv = $urandom_range(9, 32);
        default: wv = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 19))
        0: hv = $urandom_range(0, 2);
        1: hv = $urandom_range(0, 1) ? 65535 : $urandom_range(17, 65535);
        default: hv = $urandom_range(3, 6);
      endcase
      write_reg(REG_FRAME_WIDTH, with_noise(wv, FW_BITS));
      write_reg(REG_FRAME_HEIGHT, with_noise(hv, ROW_BITS));
      w = eff_width(width_reg);
      h = (height_reg < 3) ? 3 : height_reg;
      // Tall frames are only sampled for a few rows.
      frame_items = (h > 16) ? w * $urandom_range(3, 6) : w * h;
      n_frames = (frame_items > 60) ? 1 : $urandom_range(1, 4);
      for (int f = 0; f < n_frames; f++) begin
        leading = ($urandom_range(0, 5) != 0);
        pause_at = -1;
        if (f == 0 && (phase == 2 || $urandom_range(0, 4) == 0))
          pause_at = $urandom_range(1, frame_items - 2);
        for (int i = 0; i < frame_items; i++) begin
          noise = $urandom_range(0, 99);
          if (noise < 2) break;
          fs = (i == 0 && leading) || (noise < 5);
          send_pixel(pick_sample(), fs);
          if (i == pause_at) settle();
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    window_result_t got, want;
    int roll;
    if (rst_n && out_valid && out_ready) begin
      got = '{sum: conv_value, row: out_row, col: out_col, last: last_of_frame};
      if (expected_sums.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("mismatch: unexpected beat sum=%0d row=%0d col=%0d last=%0b",
                   $signed(got.sum), got.row, got.col, got.last);
      end else begin
        want = expected_sums.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch: expected sum=%0d row=%0d col=%0d last=%0b,",
                     $signed(want.sum), want.row, want.col, want.last,
                     " got sum=%0d row=%0d col=%0d last=%0b",
                     $signed(got.sum), got.row, got.col, got.last);
        end
      end
    end
    // Stalls come as single cycles and as short bursts that fill the output queue.
    if (steady) begin
      hold_left = 0;
      out_ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 999);
      if (roll < 4) begin
        hold_left = $urandom_range(8, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (roll >= 44);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    for (int kr = 0; kr < 3; kr++) begin
      kernel_rows[kr] = '0;
      for (int kc = 0; kc < 3; kc++) window_cells[kr][kc] = '0;
    end
    row_pos      = 0;
    col_pos      = 0;
    width_reg    = FRAME_WIDTH_RESET;
    height_reg   = FRAME_HEIGHT_RESET;
    restart_due  = 1'b0;
    pixels_sent  = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    hold_left    = 0;
    steady       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extreme_values();
    test_frame_extremes();
    test_midframe_config();
    test_random_stream();
    settle();
    if (mismatch_cnt == 0 && expected_sums.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
